@@ sv/biped_camera_pose_kinematics_defines.svh @@
// Assertion macros used by the checker file.
`ifndef BIPED_CAMERA_POSE_KINEMATICS_DEFINES_SVH
`define BIPED_CAMERA_POSE_KINEMATICS_DEFINES_SVH

// Property that is checked outside reset.
`define BCPK_ASSERT_RUN(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error("bcpk assertion failed");

// Property that is checked at every edge, reset included.
`define BCPK_ASSERT_ALL(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
   else $error("bcpk assertion failed");

`endif

@@ sv/bcpk_pkg.sv @@
// Shared types and constants of the camera pose kinematics pipeline.
package bcpk_pkg;

   localparam int LANES  = 12;
   localparam int STAGES = 13;

   // lane map: per leg cos tibia, cos thigh, cos torso, cos head, sin head; then yaw sin, cos
   localparam int LANE_L    = 0;
   localparam int LANE_R    = 5;
   localparam int LANE_YSIN = 10;
   localparam int LANE_YCOS = 11;
   localparam logic [LANES-1:0] LANE_COS = 12'b1001_1110_1111;

   localparam logic [30:0] COEF_C1 = 31'd1686629713;
   localparam logic [30:0] COEF_C3 = 31'd693598669;
   localparam logic [30:0] COEF_C5 = 31'd85569306;
   localparam logic [30:0] COEF_C7 = 31'd5026995;
   localparam logic [30:0] COEF_C9 = 31'd172272;

   typedef enum logic [2:0] {
      CSR_OFFSET = 3'd0,
      CSR_G2A    = 3'd1,
      CSR_A2K    = 3'd2,
      CSR_K2H    = 3'd3,
      CSR_H2N    = 3'd4,
      CSR_CAM_Z  = 3'd5,
      CSR_CAM_X  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [15:0] offset;
      logic [15:0] g2a;
      logic [15:0] a2k;
      logic [15:0] k2h;
      logic [15:0] h2n;
      logic [15:0] cam_z;
      logic [15:0] cam_x;
   } cfg_type;

   typedef struct packed {
      logic [14:0] q;
      logic [14:0] t;
      logic [30:0] r;
      logic        neg;
   } lane_type;

   typedef lane_type [LANES-1:0] lane_vec_type;

   typedef struct packed {
      logic [17:0] tilt_l;
      logic [17:0] tilt_r;
      logic [15:0] azim;
   } ctx_type;

endpackage

@@ sv/bcpk_front.sv @@
// Front stages: joint sums, tilt, phase and quarter-wave folding, argument square.
module bcpk_front (
   input  logic                  clock,
   input  logic [2:0]            en,
   input  logic [127:0]          angles,
   input  logic [15:0]           offset,
   output bcpk_pkg::lane_vec_type lanes,
   output bcpk_pkg::ctx_type     ctx
);

   logic signed [17:0] ang_in [bcpk_pkg::LANES];
   logic signed [17:0] ang_ff [bcpk_pkg::LANES];
   bcpk_pkg::ctx_type  ctx0_in, ctx0_ff, ctx1_ff, ctx2_ff;
   logic [14:0]        q_in [bcpk_pkg::LANES];
   logic [14:0]        q_ff [bcpk_pkg::LANES];
   logic               n_in [bcpk_pkg::LANES];
   logic               n_ff [bcpk_pkg::LANES];
   bcpk_pkg::lane_vec_type lanes_in, lanes_ff;

   logic signed [17:0] tib_l, thi_l, tor_l, hd_l, tib_r, thi_r, tor_r, hd_r, yaw;
   logic signed [19:0] tl, tr;
   logic signed [16:0] az;

   always_comb begin
      tib_l = 18'($signed(angles[15:0]));
      thi_l = tib_l + 18'($signed(angles[31:16]));
      tor_l = thi_l + 18'($signed(angles[47:32]));
      hd_l  = tor_l + 18'($signed(angles[111:96]));
      tib_r = 18'($signed(angles[63:48]));
      thi_r = tib_r + 18'($signed(angles[79:64]));
      tor_r = thi_r + 18'($signed(angles[95:80]));
      hd_r  = tor_r + 18'($signed(angles[111:96]));
      yaw   = 18'($signed(angles[127:112]));
      ang_in[0] = tib_l; ang_in[1] = thi_l; ang_in[2] = tor_l;
      ang_in[3] = hd_l;  ang_in[4] = hd_l;
      ang_in[5] = tib_r; ang_in[6] = thi_r; ang_in[7] = tor_r;
      ang_in[8] = hd_r;  ang_in[9] = hd_r;
      ang_in[10] = yaw;  ang_in[11] = yaw;
      tl = 20'sd6434 - 20'(hd_l) - 20'($signed(offset));
      tr = 20'sd6434 - 20'(hd_r) - 20'($signed(offset));
      az = -17'($signed(angles[127:112]));
      ctx0_in.tilt_l = (tl > 20'sd131071) ? 18'h1FFFF :
                       (tl < -20'sd131072) ? 18'h20000 : tl[17:0];
      ctx0_in.tilt_r = (tr > 20'sd131071) ? 18'h1FFFF :
                       (tr < -20'sd131072) ? 18'h20000 : tr[17:0];
      ctx0_in.azim   = (az > 17'sd32767) ? 16'h7FFF : az[15:0];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         ang_ff  <= ang_in;
         ctx0_ff <= ctx0_in;
      end
   end

   // phase in 1/65536 turn, then fold into a quarter wave
   always_comb begin
      logic signed [36:0] pm;
      logic [15:0]        p;
      for (int i = 0; i < bcpk_pkg::LANES; i++) begin
         pm = 37'(ang_ff[i]) * 37'sd166886 + 37'sd32768;
         p  = pm[31:16] + (bcpk_pkg::LANE_COS[i] ? 16'd16384 : 16'd0);
         q_in[i] = p[14] ? (15'd16384 - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
         n_in[i] = p[15];
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         q_ff    <= q_in;
         n_ff    <= n_in;
         ctx1_ff <= ctx0_ff;
      end
   end

   always_comb begin
      logic [29:0] sq;
      for (int i = 0; i < bcpk_pkg::LANES; i++) begin
         sq = 30'(q_ff[i]) * 30'(q_ff[i]);
         lanes_in[i].q   = q_ff[i];
         lanes_in[i].t   = sq[28:14];
         lanes_in[i].r   = bcpk_pkg::COEF_C9;
         lanes_in[i].neg = n_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         lanes_ff <= lanes_in;
         ctx2_ff  <= ctx1_ff;
      end
   end

   assign lanes = lanes_ff;
   assign ctx   = ctx2_ff;

endmodule

@@ sv/bcpk_horner_cell.sv @@
// One polynomial step on every trig lane: r = coef - (r * t) >> 14.
module bcpk_horner_cell (
   input  logic                   clock,
   input  logic                   en,
   input  logic [30:0]            coef,
   input  bcpk_pkg::lane_vec_type lanes_in,
   input  bcpk_pkg::ctx_type      ctx_in,
   output bcpk_pkg::lane_vec_type lanes_out,
   output bcpk_pkg::ctx_type      ctx_out
);

   bcpk_pkg::lane_vec_type lanes_in_c, lanes_ff;
   bcpk_pkg::ctx_type      ctx_ff;

   always_comb begin
      logic [45:0] pr;
      logic [31:0] df;
      for (int i = 0; i < bcpk_pkg::LANES; i++) begin
         pr = 46'(lanes_in[i].r) * 46'(lanes_in[i].t);
         df = {1'b0, coef} - pr[45:14];
         lanes_in_c[i]   = lanes_in[i];
         lanes_in_c[i].r = df[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lanes_ff <= lanes_in_c;
         ctx_ff   <= ctx_in;
      end
   end

   assign lanes_out = lanes_ff;
   assign ctx_out   = ctx_ff;

endmodule

@@ sv/bcpk_back.sv @@
// Back stages: final sine scale, link products, sums, leg choice, yaw rotation, saturation.
module bcpk_back (
   input  logic                   clock,
   input  logic [5:0]             en,
   input  bcpk_pkg::cfg_type      cfg,
   input  bcpk_pkg::lane_vec_type lanes,
   input  bcpk_pkg::ctx_type      ctx,
   output logic [93:0]            result
);

   function automatic logic [19:0] sat20(input logic signed [67:0] v);
      if (v > 68'sd524287) return 20'h7FFFF;
      if (v < -68'sd524288) return 20'h80000;
      return v[19:0];
   endfunction

   // stage: sine value in Q30, signed
   logic signed [31:0] trig_in [bcpk_pkg::LANES];
   logic signed [31:0] trig_ff [bcpk_pkg::LANES];
   bcpk_pkg::ctx_type  ctx7_ff, ctx8_ff, ctx9_ff;

   always_comb begin
      logic [45:0] pr;
      logic [31:0] v;
      for (int i = 0; i < bcpk_pkg::LANES; i++) begin
         pr = 46'(lanes[i].r) * 46'(lanes[i].q);
         v  = (pr[45:14] > 32'd1073741824) ? 32'd1073741824 : pr[45:14];
         trig_in[i] = lanes[i].neg ? -$signed(v) : $signed(v);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         trig_ff <= trig_in;
         ctx7_ff <= ctx;
      end
   end

   // stage: link products, per leg [0] left and [1] right
   logic signed [48:0] p_in [2][7];
   logic signed [48:0] p_ff [2][7];
   logic signed [31:0] ys_ff, yc_ff, ys9_ff, yc9_ff, ys10_ff, yc10_ff;
   logic signed [16:0] a2k, k2h, h2n, nz, nx;

   always_comb begin
      int b;
      a2k = $signed({1'b0, cfg.a2k});
      k2h = $signed({1'b0, cfg.k2h});
      h2n = $signed({1'b0, cfg.h2n});
      nz  = 17'($signed(cfg.cam_z));
      nx  = 17'($signed(cfg.cam_x));
      for (int g = 0; g < 2; g++) begin
         b = (g == 0) ? bcpk_pkg::LANE_L : bcpk_pkg::LANE_R;
         p_in[g][0] = 49'(trig_ff[b])   * 49'(a2k);
         p_in[g][1] = 49'(trig_ff[b+1]) * 49'(k2h);
         p_in[g][2] = 49'(trig_ff[b+2]) * 49'(h2n);
         p_in[g][3] = 49'(trig_ff[b+3]) * 49'(nz);
         p_in[g][4] = 49'(trig_ff[b+4]) * 49'(nx);
         p_in[g][5] = 49'(trig_ff[b+3]) * 49'(nx);
         p_in[g][6] = 49'(trig_ff[b+4]) * 49'(nz);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         p_ff    <= p_in;
         ys_ff   <= trig_ff[bcpk_pkg::LANE_YSIN];
         yc_ff   <= trig_ff[bcpk_pkg::LANE_YCOS];
         ctx8_ff <= ctx7_ff;
      end
   end

   // stage: sums and rounding
   logic signed [21:0] ht_in [2];
   logic signed [21:0] ht_ff [2];
   logic signed [33:0] fw_in [2];
   logic signed [33:0] fw_ff [2];

   always_comb begin
      logic signed [51:0] h;
      logic signed [51:0] f;
      for (int g = 0; g < 2; g++) begin
         h = $signed({4'd0, cfg.g2a, 30'd0}) + 52'(p_ff[g][0]) + 52'(p_ff[g][1])
           + 52'(p_ff[g][2]) + 52'(p_ff[g][3]) - 52'(p_ff[g][4]) + 52'sd536870912;
         f = 52'(p_ff[g][5]) + 52'(p_ff[g][6]) + 52'sd32768;
         ht_in[g] = h[51:30];
         fw_in[g] = f[49:16];
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         ht_ff   <= ht_in;
         fw_ff   <= fw_in;
         ys9_ff  <= ys_ff;
         yc9_ff  <= yc_ff;
         ctx9_ff <= ctx8_ff;
      end
   end

   // stage: take the taller leg, right leg on a tie
   logic               left_sel;
   logic signed [21:0] hsel_ff;
   logic signed [33:0] fsel_ff;
   logic [17:0]        tilt10_ff;
   logic [15:0]        az10_ff;

   assign left_sel = ht_ff[0] > ht_ff[1];

   always_ff @(posedge clock) begin
      if (en[3]) begin
         hsel_ff   <= left_sel ? ht_ff[0] : ht_ff[1];
         fsel_ff   <= left_sel ? fw_ff[0] : fw_ff[1];
         tilt10_ff <= left_sel ? ctx9_ff.tilt_l : ctx9_ff.tilt_r;
         az10_ff   <= ctx9_ff.azim;
         ys10_ff   <= ys9_ff;
         yc10_ff   <= yc9_ff;
      end
   end

   // stage: yaw rotation products
   logic signed [66:0] mx_ff, my_ff;
   logic [19:0]        h11_ff;
   logic [17:0]        tilt11_ff;
   logic [15:0]        az11_ff;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         mx_ff     <= 67'(ys10_ff) * 67'(fsel_ff);
         my_ff     <= 67'(yc10_ff) * 67'(fsel_ff);
         h11_ff    <= sat20(68'(hsel_ff));
         tilt11_ff <= tilt10_ff;
         az11_ff   <= az10_ff;
      end
   end

   // stage: round, saturate, output register
   logic signed [67:0] wx, wy;
   logic [93:0]        res_in, res_ff;

   always_comb begin
      wx = -68'(mx_ff) + 68'sd8796093022208;
      wy =  68'(my_ff) + 68'sd8796093022208;
      res_in = {az11_ff, h11_ff, sat20(wy >>> 44), sat20(wx >>> 44), tilt11_ff};
   end

   always_ff @(posedge clock) begin
      if (en[5]) res_ff <= res_in;
   end

   assign result = res_ff;

endmodule

@@ sv/biped_camera_pose_kinematics.sv @@
// Biped camera pose kinematics: top level with register file and pipeline control.
//
// Input stream req_*: one beat carries eight joint angles (1/4096 rad). Result
// stream rsp_*: one beat per input beat with tilt, world x/y, height and azimuth,
// in input order. Configuration: csr_valid/csr_index/csr_data write one of seven
// 16-bit registers; csr_ready is always high and indexes above 6 are dropped.
// Write registers only while no beat is in flight.
// Throughput is one beat per cycle while rsp_tready is high, set by a chain of
// 13 register stages: sums, phase, square, four polynomial cells, sine scale,
// link products, sums, leg choice, yaw products and the output register.
// Each stage holds a valid bit; a stage advances when it is empty or the stage
// after it advances, so empty slots are squeezed out while rsp_tready is low and
// req_tready stays high until the whole chain is full.
// Reset clears all valid bits and sets the seven configuration registers to zero.
module biped_camera_pose_kinematics (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // left_ankle, left_knee, left_hip, right_ankle, right_knee, right_hip,
   // neck pitch, neck yaw angles, 16 bits each
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // camera_tilt[17:0], camera_x[37:18], camera_y[57:38], camera_height[77:58],
   // camera_azimuth[93:78], zero pad [95:94]
   output logic [95:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_data
);

   localparam int N = bcpk_pkg::STAGES;

   bcpk_pkg::cfg_type cfg_ff;
   logic [N-1:0]      vld_ff, vld_in;
   logic [N:0]        adv;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         case (bcpk_pkg::csr_index_type'(csr_index))
            bcpk_pkg::CSR_OFFSET: cfg_ff.offset <= csr_data;
            bcpk_pkg::CSR_G2A:    cfg_ff.g2a    <= csr_data;
            bcpk_pkg::CSR_A2K:    cfg_ff.a2k    <= csr_data;
            bcpk_pkg::CSR_K2H:    cfg_ff.k2h    <= csr_data;
            bcpk_pkg::CSR_H2N:    cfg_ff.h2n    <= csr_data;
            bcpk_pkg::CSR_CAM_Z:  cfg_ff.cam_z  <= csr_data;
            bcpk_pkg::CSR_CAM_X:  cfg_ff.cam_x  <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      adv[N] = rsp_tready;
      for (int i = N - 1; i >= 0; i--) adv[i] = !vld_ff[i] || adv[i+1];
      vld_in = {vld_ff[N-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < N; i++) if (adv[i]) vld_ff[i] <= vld_in[i];
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = vld_ff[N-1];

   bcpk_pkg::lane_vec_type lanes2, lanes3, lanes4, lanes5, lanes6;
   bcpk_pkg::ctx_type      ctx2, ctx3, ctx4, ctx5, ctx6;
   logic [93:0]            result;

   bcpk_front u_front (
      .clock(clock), .en(adv[2:0]), .angles(req_tdata), .offset(cfg_ff.offset),
      .lanes(lanes2), .ctx(ctx2)
   );

   bcpk_horner_cell u_cell7 (
      .clock(clock), .en(adv[3]), .coef(bcpk_pkg::COEF_C7),
      .lanes_in(lanes2), .ctx_in(ctx2), .lanes_out(lanes3), .ctx_out(ctx3)
   );
   bcpk_horner_cell u_cell5 (
      .clock(clock), .en(adv[4]), .coef(bcpk_pkg::COEF_C5),
      .lanes_in(lanes3), .ctx_in(ctx3), .lanes_out(lanes4), .ctx_out(ctx4)
   );
   bcpk_horner_cell u_cell3 (
      .clock(clock), .en(adv[5]), .coef(bcpk_pkg::COEF_C3),
      .lanes_in(lanes4), .ctx_in(ctx4), .lanes_out(lanes5), .ctx_out(ctx5)
   );
   bcpk_horner_cell u_cell1 (
      .clock(clock), .en(adv[6]), .coef(bcpk_pkg::COEF_C1),
      .lanes_in(lanes5), .ctx_in(ctx5), .lanes_out(lanes6), .ctx_out(ctx6)
   );

   bcpk_back u_back (
      .clock(clock), .en(adv[12:7]), .cfg(cfg_ff), .lanes(lanes6), .ctx(ctx6),
      .result(result)
   );

   assign rsp_tdata = {2'b00, result};

endmodule

@@ sv/bcpk_checker.sv @@
// Port-level checker for the camera pose kinematics block, with its bind.
`include "biped_camera_pose_kinematics_defines.svh"

module bcpk_checker (
   input logic clock,
   input logic reset,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic csr_ready
);

   `BCPK_ASSERT_RUN(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `BCPK_ASSERT_ALL(a_reset_empty, clock, reset |=> !rsp_tvalid)
   `BCPK_ASSERT_RUN(a_flow_through, clock, reset, rsp_tready |-> req_tready)
   `BCPK_ASSERT_ALL(a_csr_ready, clock, csr_ready)

endmodule

bind biped_camera_pose_kinematics bcpk_checker u_bcpk_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .csr_ready(csr_ready)
);
